### rtl/core/fcms_pkg.sv
package fcms_pkg;

  // Operation codes carried in the low bits of an input item
  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_ERASE_ALL = 2'd1,
    OP_ERASE_ONE = 2'd2,
    OP_COUNT     = 2'd3
  } op_t;

  // Stream field widths and placement
  localparam int unsigned OP_W      = 2;
  localparam int unsigned VAL_IN_W  = 32;
  localparam int unsigned CNT_OUT_W = 6;
  localparam int unsigned IN_W      = 40;
  localparam int unsigned OUT_W     = 16;

  // Read address source for the table memory
  typedef enum logic [1:0] {
    RD_AT_I   = 2'd0,
    RD_NEXT_I = 2'd1,
    RD_TAIL   = 2'd2
  } rd_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load;
    logic    ins_wr;
    logic    ovf_set;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    step;
    logic    hit;
    logic    place;
  } fcms_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic match;
    logic last;
  } fcms_sts_t;

endpackage

### rtl/core/fixed_capacity_multiset_table_core.sv
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_tvalid/tready    | op, value
// out_    | output    | out_tvalid/tready   | tally, found, overflow, fill
//
// Insert: the result follows S_INS, which appends the value or flags overflow.
// Erase and count scan the table from slot 0: S_FETCH, then S_CMP on each held slot;
// a removed entry not in the last held slot adds an S_PLACE (tail write-back; the
// tail read overlaps the compare). An empty table skips the scan.
// The single table memory port pair (one read, one write) sets the scan rate.
// Reset clears the entry count and the controller state only; table contents need no clearing.
// One item at a time: in_tready is low from accept until the cycle after the result
// is taken.
module fixed_capacity_multiset_table_core
  import fcms_pkg::*;
#(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // op[1:0], value[33:2], zero pad
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // tally[5:0], found[6], overflow[7],
                                       // fill[13:8], zero pad
);

  op_t                    in_op;
  logic [VAL_IN_W-1:0]    in_value;
  fcms_cmd_t              cmd;
  fcms_sts_t              sts;
  logic [CNT_OUT_W-1:0]   res_tally;
  logic                   res_found;
  logic                   res_overflow;
  logic [CNT_OUT_W-1:0]   res_fill;

  // Unpack input item
  assign in_op    = op_t'(in_tdata[OP_W-1:0]);
  assign in_value = in_tdata[OP_W+VAL_IN_W-1:OP_W];

  fcms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_op),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fcms_dp #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_op        (in_op),
    .in_value     (in_value),
    .cmd          (cmd),
    .sts          (sts),
    .res_tally    (res_tally),
    .res_found    (res_found),
    .res_overflow (res_overflow),
    .res_fill     (res_fill)
  );

  // Pack result item
  assign out_tdata = {2'b00, res_fill, res_overflow, res_found, res_tally};

  // A result and a new item never overlap
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while result pending");

  // Insert into a full table reports overflow in S_DONE, after S_INS sets the flag
  a_full_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_op == OP_INSERT && sts.full)
      |-> ##2 (out_tvalid && res_overflow))
    else $error("overflow not reported on full insert");

  // Fill holds while idle
  a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tready && !in_tvalid) |=> $stable(res_fill))
    else $error("entry count changed while idle");

  // Write-back never targets an empty table
  a_place_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place |-> !sts.empty)
    else $error("slot refill with no entries held");

endmodule

### rtl/core/fcms_ctrl.sv
module fcms_ctrl
  import fcms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  op_t       in_op,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  fcms_sts_t sts,
  output fcms_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_FETCH,
    S_CMP,
    S_PLACE,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_op == OP_INSERT) begin
            state_nxt = S_INS;
          end else if (sts.empty) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_INS: begin
        if (sts.full) begin
          cmd.ovf_set = 1'b1;
        end else begin
          cmd.ins_wr = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_FETCH: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_AT_I;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        if (sts.match && sts.op != OP_COUNT) begin
          // Remove this entry; unless it is the last held one, pull the tail entry into its slot
          cmd.hit = 1'b1;
          if (sts.last) begin
            state_nxt = S_DONE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_TAIL;
            state_nxt  = S_PLACE;
          end
        end else begin
          cmd.hit = sts.match;
          if (sts.last) begin
            state_nxt = S_DONE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_NEXT_I;
            cmd.step   = 1'b1;
          end
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        // Erase-all rechecks the moved entry, erase-one is finished
        state_nxt = (sts.op == OP_ERASE_ALL) ? S_CMP : S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/fcms_dp.sv
module fcms_dp
  import fcms_pkg::*;
#(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  op_t                   in_op,
  input  logic [VAL_IN_W-1:0]   in_value,
  input  fcms_cmd_t             cmd,
  output fcms_sts_t             sts,
  output logic [CNT_OUT_W-1:0]  res_tally,
  output logic                  res_found,
  output logic                  res_overflow,
  output logic [CNT_OUT_W-1:0]  res_fill
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic [VALUE_BITS-1:0] key_r;
  op_t                   op_r;
  logic [AW-1:0]         i_r, i_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         tally_r, tally_nxt;
  logic                  found_r, found_nxt;
  logic                  ovf_r, ovf_nxt;

  logic [CW-1:0]         tail_cnt;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  assign tail_cnt = count_r - CW'(1);

  // Status toward the controller
  assign sts.op    = op_r;
  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CW'(DEPTH));
  assign sts.match = (rd_data_r == key_r);
  assign sts.last  = ((CW'(i_r) + CW'(1)) >= count_r);

  // Select read address
  always_comb begin
    case (cmd.rd_sel)
      RD_NEXT_I: rd_addr = AW'(i_r + 1'b1);
      RD_TAIL:   rd_addr = tail_cnt[AW-1:0];
      default:   rd_addr = i_r;
    endcase
  end

  // Select write port: append on insert, fill vacated slot on place
  always_comb begin
    wr_en   = cmd.ins_wr | cmd.place;
    wr_addr = cmd.place ? i_r : count_r[AW-1:0];
    wr_data = cmd.place ? rd_data_r : key_r;
  end

  // Table memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Next values of scan index, count and result flags
  always_comb begin
    i_nxt     = i_r;
    count_nxt = count_r;
    tally_nxt = tally_r;
    found_nxt = found_r;
    ovf_nxt   = ovf_r;
    if (cmd.load) begin
      i_nxt     = '0;
      tally_nxt = '0;
      found_nxt = 1'b0;
      ovf_nxt   = 1'b0;
    end
    if (cmd.step) begin
      i_nxt = AW'(i_r + 1'b1);
    end
    if (cmd.ins_wr) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.ovf_set) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.hit) begin
      if (op_r != OP_COUNT) begin
        count_nxt = tail_cnt;
      end
      if (op_r == OP_ERASE_ONE) begin
        found_nxt = 1'b1;
      end else begin
        tally_nxt = tally_r + CW'(1);
      end
    end
  end

  // Clear count under reset, latch the rest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    tally_r <= tally_nxt;
    found_r <= found_nxt;
    ovf_r   <= ovf_nxt;
    if (cmd.load) begin
      op_r  <= in_op;
      key_r <= VALUE_BITS'(in_value);
    end
  end

  // Results, counts reported modulo 64
  assign res_tally    = CNT_OUT_W'(tally_r);
  assign res_found    = found_r;
  assign res_overflow = ovf_r;
  assign res_fill     = CNT_OUT_W'(count_r);

endmodule

### bench/tb_top.sv
module tb_top;
  import fcms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 120;

  // One result item, unpacked from out_tdata
  typedef struct packed {
    logic [5:0] tally;
    logic       found;
    logic       overflow;
    logic [5:0] fill;
  } result_t;

  // Shadow copy of the table plus the queue of results it predicts
  class multiset_shadow;
    logic [31:0] slots[TABLE_DEPTH];
    int unsigned held;
    result_t     pending_results[$];
    int unsigned errors;

    function new();
      held = 0;
      errors = 0;
    endfunction

    // Apply one accepted item to the shadow table and queue its result
    function void apply_item(op_t op, logic [31:0] value);
      result_t r;
      int unsigned i;
      r = '0;
      case (op)
        OP_INSERT: begin
          if (held >= TABLE_DEPTH) begin
            r.overflow = 1'b1;
          end else begin
            slots[held] = value;
            held++;
          end
        end
        OP_ERASE_ALL: begin
          i = 0;
          while (i < held) begin
            if (slots[i] == value) begin
              held--;
              slots[i] = slots[held];
              r.tally++;
            end else begin
              i++;
            end
          end
        end
        OP_ERASE_ONE: begin
          for (i = 0; i < held; i++) begin
            if (slots[i] == value) begin
              held--;
              slots[i] = slots[held];
              r.found = 1'b1;
              break;
            end
          end
        end
        default: begin
          for (i = 0; i < held; i++)
            if (slots[i] == value)
              r.tally++;
        end
      endcase
      r.fill = held[5:0];
      pending_results.push_back(r);
    endfunction

    function void report_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(logic [OUT_W-1:0] word);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, word);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      report_field("tally", {2'b0, want.tally}, {2'b0, word[5:0]});
      report_field("found", {7'b0, want.found}, {7'b0, word[6]});
      report_field("overflow", {7'b0, want.overflow}, {7'b0, word[7]});
      report_field("fill", {2'b0, want.fill}, {2'b0, word[13:8]});
      report_field("pad", 8'd0, {6'b0, word[15:14]});
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  multiset_shadow shadow = new();

  int unsigned cycle_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  logic [31:0] value_pool[6];

  fixed_capacity_multiset_table_core #(
    .DEPTH(TABLE_DEPTH),
    .VALUE_BITS(32)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  // Take results and stall the result side on a shifting pattern
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (out_tvalid && out_tready)
      shadow.check_result(out_tdata);
    case ((cycle_cnt / 300) % 4)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (cycle_cnt % 5) == 0;
      default: out_tready <= (cycle_cnt % 17) >= 12;
    endcase
  end

  // End the run when no item moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one item, inserting a random gap between bursts
  task automatic issue(op_t op, logic [31:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, value, op};
    do @(posedge clk); while (!in_tready);
    shadow.apply_item(op, value);
  endtask

  // Mostly values from a small pool so that duplicates pile up
  function automatic logic [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65)
      return value_pool[$urandom_range(0, 5)];
    if (roll < 80)
      return value_pool[$urandom_range(0, 5)] ^ (32'd1 << $urandom_range(0, 31));
    return $urandom;
  endfunction

  // Bias the operation mix toward filling or draining the table
  function automatic op_t pick_op(bit filling);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 70) return OP_INSERT;
      if (roll < 80) return OP_ERASE_ONE;
      if (roll < 85) return OP_ERASE_ALL;
      return OP_COUNT;
    end
    if (roll < 25) return OP_INSERT;
    if (roll < 60) return OP_ERASE_ONE;
    if (roll < 80) return OP_ERASE_ALL;
    return OP_COUNT;
  endfunction

  initial begin
    int unsigned n;
    int unsigned phase_left;
    bit          filling;

    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < 6; k++)
      value_pool[k] = $urandom;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extremes, absent values, duplicates
    issue(OP_COUNT, 32'h0000_0000);
    issue(OP_ERASE_ONE, 32'hFFFF_FFFF);
    issue(OP_ERASE_ALL, 32'h0000_0000);
    issue(OP_INSERT, 32'hFFFF_FFFF);
    issue(OP_INSERT, 32'h0000_0000);
    issue(OP_INSERT, 32'hFFFF_FFFF);
    issue(OP_INSERT, 32'h8000_0000);
    issue(OP_INSERT, 32'hFFFF_FFFF);
    issue(OP_COUNT, 32'hFFFF_FFFF);
    issue(OP_COUNT, 32'h7FFF_FFFF);
    issue(OP_ERASE_ONE, 32'hFFFF_FFFF);
    issue(OP_ERASE_ONE, 32'h1234_5678);
    issue(OP_ERASE_ALL, 32'h0000_0001);
    issue(OP_COUNT, 32'hFFFF_FFFF);
    issue(OP_ERASE_ALL, 32'hFFFF_FFFF);
    issue(OP_COUNT, 32'hFFFF_FFFF);
    issue(OP_ERASE_ONE, 32'h8000_0000);
    issue(OP_ERASE_ONE, 32'h0000_0000);
    issue(OP_ERASE_ALL, 32'h0000_0000);
    issue(OP_COUNT, 32'h0000_0000);

    // Random: alternate fill-heavy and drain-heavy phases
    filling = 1'b1;
    phase_left = 90;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        filling = ~filling;
        phase_left = $urandom_range(30, 100);
        if ($urandom_range(0, 3) == 0)
          value_pool[$urandom_range(2, 5)] = $urandom;
      end
      phase_left--;
      issue(pick_op(filling), pick_value());
    end

    // Wait out every result, then a little longer for stray output
    in_tvalid <= 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/fcms_pkg.sv
rtl/core/fcms_ctrl.sv
rtl/core/fcms_dp.sv
rtl/core/fixed_capacity_multiset_table_core.sv
bench/tb_top.sv
